// ===== hw/rtl/wlsm_pkg.sv =====
package wlsm_pkg;

	localparam int NumLayers = 256;
	localparam int IdW = 8;
	localparam int HtW = 9;

	localparam logic [2:0] ActAlloc   = 3'd0;
	localparam logic [2:0] ActSize    = 3'd1;
	localparam logic [2:0] ActHeight  = 3'd2;
	localparam logic [2:0] ActSlide   = 3'd3;
	localparam logic [2:0] ActRefresh = 3'd4;
	localparam logic [2:0] ActFree    = 3'd5;

	localparam logic [1:0] KindAck    = 2'd0;
	localparam logic [1:0] KindMap    = 2'd1;
	localparam logic [1:0] KindRedraw = 2'd2;

	// one queued redraw command before clipping
	typedef struct packed {
		logic [1:0]         kind;
		logic               status;
		logic [7:0]         layer;
		logic signed [14:0] x0;
		logic signed [14:0] y0;
		logic signed [14:0] x1;
		logic signed [14:0] y1;
		logic signed [9:0]  from_h;
		logic signed [8:0]  to_h;
		logic               last;
	} cmd_t;

	function automatic logic [11:0] clip(input logic signed [14:0] v, input logic [11:0] hi);
		logic [11:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({3'b0, hi})) begin
			r = hi;
		end else begin
			r = v[11:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/wlsm_emit.sv =====
module wlsm_emit
	import wlsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        emit_valid,
	input  cmd_t        emit_cmd,
	input  logic [11:0] scr_w,
	input  logic [11:0] scr_h,
	output logic        done,
	output logic [1:0]  kind,
	output logic        status,
	output logic [7:0]  layer_out,
	output logic [11:0] rect_x0,
	output logic [11:0] rect_y0,
	output logic [11:0] rect_x1,
	output logic [11:0] rect_y1,
	output logic signed [9:0] from_height,
	output logic signed [8:0] to_height,
	output logic        last
);
	// registered result port with clipping
	cmd_t c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			c_q <= emit_cmd;
		end
	end

	always_comb begin
		kind        = c_q.kind;
		status      = c_q.status;
		layer_out   = c_q.layer;
		last        = c_q.last;
		if (c_q.kind == KindAck) begin
			rect_x0 = '0;
			rect_y0 = '0;
			rect_x1 = '0;
			rect_y1 = '0;
			from_height = '0;
			to_height = '0;
		end else begin
			rect_x0 = clip(c_q.x0, scr_w);
			rect_y0 = clip(c_q.y0, scr_h);
			rect_x1 = clip(c_q.x1, scr_w);
			rect_y1 = clip(c_q.y1, scr_h);
			from_height = c_q.from_h;
			to_height = c_q.to_h;
		end
	end
endmodule

// ===== hw/rtl/window_layer_stack_manager.sv =====
// window layer stack manager: z-ordered layers with redraw command output
// cost: a one-entry-per-cycle used-bit scan, or a read step and a write step per shifted entry
// results are one-cycle strobes on done; the receiver cannot stall; one request at a time
// reset: all layers free, top height -1, screen 320x200; order/height memories undefined
// after reset a pass over all 256 entries clears the position and size memories with busy held high
module window_layer_stack_manager
	import wlsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [7:0]  sheet_id,
	input  logic signed [8:0]  new_height,
	input  logic signed [12:0] pos_x,
	input  logic signed [12:0] pos_y,
	input  logic [11:0] buf_width,
	input  logic [11:0] buf_height,
	input  logic signed [12:0] corner_x1,
	input  logic signed [12:0] corner_y1,
	output logic        done,
	output logic [1:0]  kind,
	output logic        status,
	output logic [7:0]  layer_out,
	output logic [11:0] rect_x0,
	output logic [11:0] rect_y0,
	output logic [11:0] rect_x1,
	output logic [11:0] rect_y1,
	output logic signed [9:0] from_height,
	output logic signed [8:0] to_height,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_LOOK  = 10'b0000000010,
		S_ALLOC = 10'b0000000100,
		S_DEC   = 10'b0000001000,
		S_RD    = 10'b0000010000,
		S_WR    = 10'b0000100000,
		S_FIN   = 10'b0001000000,
		S_EMIT  = 10'b0010000000,
		S_WAIT  = 10'b0100000000,
		S_CLR   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [11:0] scr_w_q, scr_h_q;
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= 12'd320;
			scr_h_q <= 12'd200;
		end else if (cfg_wr) begin
			if (paddr == 3'd0) begin
				scr_w_q <= pwdata[11:0];
			end else if (paddr == 3'd4) begin
				scr_h_q <= pwdata[11:0];
			end
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == 3'd0) begin
			prdata[11:0] = scr_w_q;
		end else if (paddr == 3'd4) begin
			prdata[11:0] = scr_h_q;
		end
	end

	// per-layer storage
	logic [NumLayers-1:0] used_q;
	logic [7:0]  ord_mem [NumLayers];
	logic [8:0]  hgt_mem [NumLayers];
	logic [12:0] px_mem  [NumLayers];
	logic [12:0] py_mem  [NumLayers];
	logic [11:0] w_mem   [NumLayers];
	logic [11:0] hp_mem  [NumLayers];
	logic signed [8:0] top_q;

	// request latch
	logic [2:0]  act_q;
	logic [7:0]  id_q;
	logic signed [8:0]  req_q;
	logic signed [12:0] px_q, py_q, cx_q, cy_q;
	logic [11:0] bw_q, bh_q;

	// layer snapshot
	logic signed [9:0]  old_q;
	logic signed [12:0] ox_q, oy_q;
	logic [11:0] lw_q, lh_q;
	logic signed [9:0] tgt_q;   // clamped height
	logic signed [9:0] k_q;     // sweep index
	logic [1:0] mode_q;         // 0 lower, 1 remove, 2 raise, 3 insert
	logic [7:0] rd_q;           // registered order read
	logic [8:0] scan_q;

	// command queue, up to four entries
	cmd_t cmd_q [4];
	logic [2:0] ncmd_q;
	logic [1:0] ecnt_q;

	logic emit_valid;
	cmd_t emit_cmd;
	logic free_found;

	assign busy = (state_q != S_IDLE);

	function automatic cmd_t mk(input logic [1:0] kd, input logic [7:0] ly,
		input logic signed [14:0] a, input logic signed [14:0] b,
		input logic signed [14:0] c, input logic signed [14:0] d,
		input logic signed [9:0] f, input logic signed [9:0] t);
		cmd_t r;
		r.kind = kd; r.status = 1'b0; r.layer = ly;
		r.x0 = a; r.y0 = b; r.x1 = c; r.y1 = d;
		r.from_h = f; r.to_h = t[8:0]; r.last = 1'b0;
		return r;
	endfunction

	logic signed [14:0] ex0, ey0, ex1, ey1;
	assign ex0 = 15'(ox_q);
	assign ey0 = 15'(oy_q);
	assign ex1 = 15'(ox_q) + $signed({3'b0, lw_q});
	assign ey1 = 15'(oy_q) + $signed({3'b0, lh_q});

	logic signed [9:0] lim, clr;
	logic signed [9:0] top_w;
	assign top_w = 10'(top_q);
	always_comb begin
		lim = (old_q >= 0) ? top_w : top_w + 10'sd1;
		clr = 10'(req_q);
		if (clr > lim) clr = lim;
		if (clr < -10'sd1) clr = -10'sd1;
	end

	assign free_found = !used_q[scan_q[7:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			used_q  <= '0;
			top_q   <= -9'sd1;
			ncmd_q  <= '0;
			ecnt_q  <= '0;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					// geometry clearing pass, one entry per cycle
					if (scan_q == 9'(NumLayers - 1)) begin
						scan_q <= '0;
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + 9'd1;
					end
				end
				S_IDLE: begin
					if (start) begin
						ncmd_q <= '0;
						ecnt_q <= '0;
						scan_q <= '0;
						state_q <= (action == ActAlloc) ? S_ALLOC : S_LOOK;
					end
				end
				S_ALLOC: begin
					if (free_found) begin
						used_q[scan_q[7:0]] <= 1'b1;
						hgt_mem[scan_q[7:0]] <= -9'sd1;
						cmd_q[0] <= mk(KindAck, scan_q[7:0], '0, '0, '0, '0, '0, '0);
						ncmd_q <= 3'd1;
						state_q <= S_EMIT;
					end else if (scan_q == 9'(NumLayers - 1)) begin
						cmd_q[0] <= '{kind: KindAck, status: 1'b1, default: 0};
						ncmd_q <= 3'd1;
						state_q <= S_EMIT;
					end else begin
						scan_q <= scan_q + 9'd1;
					end
				end
				S_LOOK: begin
					state_q <= S_DEC;
					if (act_q > ActFree || !used_q[id_q]) begin
						cmd_q[0] <= mk(KindAck, id_q, '0, '0, '0, '0, '0, '0);
						ncmd_q <= 3'd1;
						state_q <= S_EMIT;
					end
				end
				S_DEC: begin
					// snapshot registers hold the layer now
					state_q <= S_FIN;
					case (act_q)
						ActSize: ;
						ActSlide: begin
							if (old_q >= 0) begin
								cmd_q[0] <= mk(KindMap, id_q, ex0, ey0, ex1, ey1, '0, top_w);
								cmd_q[1] <= mk(KindRedraw, id_q, ex0, ey0, ex1, ey1, '0,
									old_q - 10'sd1);
								cmd_q[2] <= mk(KindMap, id_q, 15'(px_q), 15'(py_q),
									15'(px_q) + $signed({3'b0, lw_q}),
									15'(py_q) + $signed({3'b0, lh_q}), old_q, top_w);
								cmd_q[3] <= mk(KindRedraw, id_q, 15'(px_q), 15'(py_q),
									15'(px_q) + $signed({3'b0, lw_q}),
									15'(py_q) + $signed({3'b0, lh_q}), old_q, old_q);
								ncmd_q <= 3'd4;
							end
						end
						ActRefresh: begin
							if (old_q >= 0) begin
								cmd_q[0] <= mk(KindRedraw, id_q, 15'(ox_q) + 15'(px_q),
									15'(oy_q) + 15'(py_q), 15'(ox_q) + 15'(cx_q),
									15'(oy_q) + 15'(cy_q), old_q, old_q);
								ncmd_q <= 3'd1;
							end
						end
						default: begin
							// height change or free
							tgt_q <= (act_q == ActFree) ? -10'sd1 : clr;
							if (act_q == ActFree && old_q < 0) begin
								state_q <= S_FIN;
							end else if (((act_q == ActFree) ? -10'sd1 : clr) < old_q) begin
								if (act_q != ActFree && clr >= 0) begin
									mode_q <= 2'd0; k_q <= old_q;
								end else begin
									mode_q <= 2'd1; k_q <= old_q;
								end
								state_q <= S_RD;
							end else if (clr > old_q) begin
								if (old_q >= 0) begin
									mode_q <= 2'd2; k_q <= old_q;
								end else begin
									mode_q <= 2'd3; k_q <= top_w;
								end
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_RD: begin
					// check loop end, else read the neighbor entry
					if ((mode_q == 2'd0 && k_q <= tgt_q) ||
						(mode_q == 2'd1 && k_q >= top_w) ||
						(mode_q == 2'd2 && k_q >= tgt_q) ||
						(mode_q == 2'd3 && k_q < tgt_q)) begin
						state_q <= S_FIN;
						if (mode_q != 2'd1) begin
							ord_mem[tgt_q[7:0]] <= id_q;
							hgt_mem[id_q] <= tgt_q[8:0];
						end else begin
							hgt_mem[id_q] <= -9'sd1;
						end
						case (mode_q)
							2'd0: begin
								cmd_q[0] <= mk(KindMap, id_q, ex0, ey0, ex1, ey1,
									tgt_q + 10'sd1, top_w);
								cmd_q[1] <= mk(KindRedraw, id_q, ex0, ey0, ex1, ey1,
									tgt_q + 10'sd1, old_q);
							end
							2'd1: begin
								top_q <= top_q - 9'sd1;
								cmd_q[0] <= mk(KindMap, id_q, ex0, ey0, ex1, ey1, '0,
									top_w - 10'sd1);
								cmd_q[1] <= mk(KindRedraw, id_q, ex0, ey0, ex1, ey1, '0,
									old_q - 10'sd1);
							end
							2'd2: begin
								cmd_q[0] <= mk(KindMap, id_q, ex0, ey0, ex1, ey1, tgt_q, top_w);
								cmd_q[1] <= mk(KindRedraw, id_q, ex0, ey0, ex1, ey1,
									tgt_q, tgt_q);
							end
							default: begin
								top_q <= top_q + 9'sd1;
								cmd_q[0] <= mk(KindMap, id_q, ex0, ey0, ex1, ey1, tgt_q,
									top_w + 10'sd1);
								cmd_q[1] <= mk(KindRedraw, id_q, ex0, ey0, ex1, ey1,
									tgt_q, tgt_q);
							end
						endcase
						ncmd_q <= 3'd2;
					end else begin
						case (mode_q)
							2'd0:    rd_q <= ord_mem[8'(k_q - 10'sd1)];
							2'd3:    rd_q <= ord_mem[k_q[7:0]];
							default: rd_q <= ord_mem[8'(k_q + 10'sd1)];
						endcase
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (mode_q == 2'd3) begin
						ord_mem[8'(k_q + 10'sd1)] <= rd_q;
						hgt_mem[rd_q] <= 9'(k_q + 10'sd1);
						k_q <= k_q - 10'sd1;
					end else begin
						ord_mem[k_q[7:0]] <= rd_q;
						hgt_mem[rd_q] <= k_q[8:0];
						k_q <= (mode_q == 2'd0) ? k_q - 10'sd1 : k_q + 10'sd1;
					end
					state_q <= S_RD;
				end
				S_FIN: begin
					if (act_q == ActFree) begin
						used_q[id_q] <= 1'b0;
					end
					if (ncmd_q == 3'd0) begin
						cmd_q[0] <= mk(KindAck, id_q, '0, '0, '0, '0, '0, '0);
						ncmd_q <= 3'd1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					ecnt_q <= ecnt_q + 2'd1;
					if (3'(ecnt_q) + 3'd1 == ncmd_q) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request latch, snapshot and plain per-layer writes
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q <= action; id_q <= sheet_id; req_q <= new_height;
			px_q <= pos_x; py_q <= pos_y; cx_q <= corner_x1; cy_q <= corner_y1;
			bw_q <= buf_width; bh_q <= buf_height;
		end
		if (state_q == S_LOOK) begin
			old_q <= 10'($signed(hgt_mem[id_q]));
			ox_q  <= px_mem[id_q];
			oy_q  <= py_mem[id_q];
			lw_q  <= w_mem[id_q];
			lh_q  <= hp_mem[id_q];
		end
		if (state_q == S_CLR) begin
			px_mem[scan_q[7:0]] <= '0; py_mem[scan_q[7:0]] <= '0;
			w_mem[scan_q[7:0]] <= '0; hp_mem[scan_q[7:0]] <= '0;
		end
		if (state_q == S_DEC && act_q == ActSize) begin
			w_mem[id_q] <= bw_q; hp_mem[id_q] <= bh_q;
		end
		if (state_q == S_DEC && act_q == ActSlide) begin
			px_mem[id_q] <= px_q; py_mem[id_q] <= py_q;
		end
	end

	always_comb begin
		emit_valid = (state_q == S_EMIT);
		emit_cmd = cmd_q[ecnt_q];
		emit_cmd.last = (3'(ecnt_q) + 3'd1 == ncmd_q);
	end

	wlsm_emit u_emit (
		.clk, .arst_n, .emit_valid, .emit_cmd,
		.scr_w(scr_w_q), .scr_h(scr_h_q),
		.done, .kind, .status, .layer_out,
		.rect_x0, .rect_y0, .rect_x1, .rect_y1,
		.from_height, .to_height, .last
	);

	property p_busy_no_done_idle;
		@(posedge clk) disable iff (!arst_n) (state_q == S_IDLE) |-> !done || last;
	endproperty
	a_idle: assert property (p_busy_no_done_idle) else $error("result outside item");
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		top_q >= -9'sd1) else $error("top height below hidden");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (ncmd_q != 3'd0 && ncmd_q <= 3'd4)) else $error("bad count");
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import wlsm_pkg::*;

	// action codes the block answers with a bare acknowledge
	localparam logic [2:0] ActSpare6 = 3'd6;
	localparam logic [2:0] ActSpare7 = 3'd7;
	localparam logic [2:0] AddrScreenW = 3'd0;
	localparam logic [2:0] AddrScreenH = 3'd4;
	localparam int IdleLimit = 3000;

	typedef struct packed {
		logic [2:0]         action;
		logic [7:0]         sheet;
		logic signed [8:0]  req_h;
		logic signed [12:0] px;
		logic signed [12:0] py;
		logic [11:0]        bw;
		logic [11:0]        bh;
		logic signed [12:0] cx;
		logic signed [12:0] cy;
	} request_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              status;
		logic [7:0]        layer;
		logic [11:0]       x0;
		logic [11:0]       y0;
		logic [11:0]       x1;
		logic [11:0]       y1;
		logic signed [9:0] from_h;
		logic signed [8:0] to_h;
		logic              last;
	} redraw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] action = '0;
	logic [7:0] sheet_id = '0;
	logic signed [8:0] new_height = '0;
	logic signed [12:0] pos_x = '0, pos_y = '0, corner_x1 = '0, corner_y1 = '0;
	logic [11:0] buf_width = '0, buf_height = '0;
	logic done, status, last, pready;
	logic [1:0] kind;
	logic [7:0] layer_out;
	logic [11:0] rect_x0, rect_y0, rect_x1, rect_y1;
	logic signed [9:0] from_height;
	logic signed [8:0] to_height;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;

	// shadow copy of the layer stack
	int scr_w, scr_h;
	int top_h;
	bit in_use [NumLayers];
	int z_of [NumLayers];
	int layer_at [NumLayers];
	int org_x [NumLayers], org_y [NumLayers];
	int wid [NumLayers], hgt [NumLayers];

	redraw_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit accepted_now;

	always #5 clk = ~clk;

	window_layer_stack_manager dut (.*);

	function automatic int clip_edge(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void queue_result(logic [1:0] k, logic st, int id,
			int x0, int y0, int x1, int y1, int f, int t);
		redraw_t r;
		r = '0;
		r.kind = k;
		r.status = st;
		r.layer = id[7:0];
		if (k != KindAck) begin
			r.x0 = 12'(clip_edge(x0, scr_w));
			r.y0 = 12'(clip_edge(y0, scr_h));
			r.x1 = 12'(clip_edge(x1, scr_w));
			r.y1 = 12'(clip_edge(y1, scr_h));
			r.from_h = 10'(f);
			r.to_h = 9'(t);
		end
		pending_results.push_back(r);
	endfunction

	function automatic void place(int k, int id);
		if (k < 0 || k >= NumLayers) return;
		layer_at[k] = id;
		z_of[id] = k;
	endfunction

	// clamp the request; on a height change, reshuffle the order table, emit map and redraw commands
	function automatic void restack(int id, int req);
		int old, lim, h, k, x0, y0, x1, y1;
		old = z_of[id];
		lim = (old >= 0) ? top_h : top_h + 1;
		h = req;
		x0 = org_x[id];
		y0 = org_y[id];
		x1 = x0 + wid[id];
		y1 = y0 + hgt[id];
		if (h > lim) h = lim;
		if (h < -1) h = -1;
		if (old > h) begin
			if (h >= 0) begin
				for (k = old; k > h; k--) place(k, layer_at[k-1]);
				place(h, id);
				queue_result(KindMap, 0, id, x0, y0, x1, y1, h + 1, top_h);
				queue_result(KindRedraw, 0, id, x0, y0, x1, y1, h + 1, old);
			end else begin
				// removal: layers above the old slot slide down by one
				z_of[id] = -1;
				for (k = old; k < top_h; k++) place(k, layer_at[k+1]);
				top_h--;
				queue_result(KindMap, 0, id, x0, y0, x1, y1, 0, top_h);
				queue_result(KindRedraw, 0, id, x0, y0, x1, y1, 0, old - 1);
			end
		end else if (old < h) begin
			if (old >= 0) begin
				for (k = old; k < h; k++) place(k, layer_at[k+1]);
			end else begin
				for (k = top_h; k >= h; k--) place(k + 1, layer_at[k]);
				top_h++;
			end
			place(h, id);
			queue_result(KindMap, 0, id, x0, y0, x1, y1, h, top_h);
			queue_result(KindRedraw, 0, id, x0, y0, x1, y1, h, h);
		end
	endfunction

	function automatic void stack_apply(request_t r);
		int n0, i, id, h, ox, oy, w, hp;
		n0 = pending_results.size();
		id = int'(r.sheet);
		if (r.action == ActAlloc) begin
			for (i = 0; i < NumLayers; i++) begin
				if (!in_use[i]) begin
					in_use[i] = 1;
					z_of[i] = -1;
					queue_result(KindAck, 0, i, 0, 0, 0, 0, 0, 0);
					break;
				end
			end
			if (pending_results.size() == n0)
				queue_result(KindAck, 1, 0, 0, 0, 0, 0, 0, 0);
		end else if (r.action <= ActFree && in_use[id]) begin
			h = z_of[id];
			ox = org_x[id];
			oy = org_y[id];
			w = wid[id];
			hp = hgt[id];
			case (r.action)
				ActSize: begin
					wid[id] = int'(r.bw);
					hgt[id] = int'(r.bh);
				end
				ActHeight: restack(id, int'(r.req_h));
				ActSlide: begin
					org_x[id] = int'(r.px);
					org_y[id] = int'(r.py);
					if (h >= 0) begin
						queue_result(KindMap, 0, id, ox, oy, ox + w, oy + hp, 0, top_h);
						queue_result(KindRedraw, 0, id, ox, oy, ox + w, oy + hp, 0, h - 1);
						queue_result(KindMap, 0, id, r.px, r.py, r.px + w, r.py + hp,
							h, top_h);
						queue_result(KindRedraw, 0, id, r.px, r.py, r.px + w, r.py + hp,
							h, h);
					end
				end
				ActRefresh: begin
					if (h >= 0)
						queue_result(KindRedraw, 0, id, ox + r.px, oy + r.py,
							ox + r.cx, oy + r.cy, h, h);
				end
				default: begin
					if (h >= 0) restack(id, -1);
					in_use[id] = 0;
				end
			endcase
		end
		if (pending_results.size() == n0)
			queue_result(KindAck, 0, id, 0, 0, 0, 0, 0, 0);
		pending_results[$].last = 1'b1;
	endfunction

	// one request: optional idle gap, then hold start until the block takes it
	task automatic send_request(request_t r, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= r.action;
		sheet_id <= r.sheet;
		new_height <= r.req_h;
		pos_x <= r.px;
		pos_y <= r.py;
		buf_width <= r.bw;
		buf_height <= r.bh;
		corner_x1 <= r.cx;
		corner_y1 <= r.cy;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		stack_apply(r);
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic request_t mk(logic [2:0] a, int id, int h = 0, int x = 0,
			int y = 0, int bw = 0, int bh = 0, int cx = 0, int cy = 0);
		request_t r;
		r.action = a;
		r.sheet = 8'(id);
		r.req_h = 9'(h);
		r.px = 13'(x);
		r.py = 13'(y);
		r.bw = 12'(bw);
		r.bh = 12'(bh);
		r.cx = 13'(cx);
		r.cy = 13'(cy);
		return r;
	endfunction

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, int value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == AddrScreenW) scr_w = value & 12'hfff;
		else scr_h = value & 12'hfff;
	endtask

	function automatic int rand_coord();
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 450) - 50;
		return $urandom_range(0, 8191) - 4096;
	endfunction

	// mostly live layers with plausible values, some noise
	function automatic request_t rand_request();
		request_t r;
		int p, id, tries;
		p = $urandom_range(0, 99);
		if (p < 10) r.action = ActAlloc;
		else if (p < 20) r.action = ActSize;
		else if (p < 55) r.action = ActHeight;
		else if (p < 70) r.action = ActSlide;
		else if (p < 85) r.action = ActRefresh;
		else if (p < 94) r.action = ActFree;
		else r.action = ($urandom_range(0, 1) != 0) ? ActSpare6 : ActSpare7;
		id = $urandom_range(0, NumLayers - 1);
		if ($urandom_range(0, 99) < 85)
			for (tries = 0; tries < 64 && !in_use[id]; tries++)
				id = $urandom_range(0, NumLayers - 1);
		r.sheet = 8'(id);
		if ($urandom_range(0, 9) < 7) r.req_h = 9'($urandom_range(0, top_h + 3) - 1);
		else r.req_h = 9'($urandom_range(0, 511));
		r.px = 13'(rand_coord());
		r.py = 13'(rand_coord());
		r.cx = 13'(rand_coord());
		r.cy = 13'(rand_coord());
		r.bw = 12'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 200)
			: $urandom_range(0, 4095));
		r.bh = 12'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 200)
			: $urandom_range(0, 4095));
		return r;
	endfunction

	task automatic run_random(int count);
		int i;
		for (i = 0; i < count; i++) send_request(rand_request(), pick_gap());
	endtask

	task automatic test_directed();
		send_request(mk(ActAlloc, 0), 0);
		send_request(mk(ActAlloc, 0), 0);
		send_request(mk(ActAlloc, 0), 2);
		// requests on a free layer or spare codes only acknowledge
		send_request(mk(ActHeight, 200, 3), 0);
		send_request(mk(ActSpare6, 0), 0);
		send_request(mk(ActSpare7, 255), 1);
		send_request(mk(ActSize, 0, 0, 0, 0, 4095, 4095), 0);
		send_request(mk(ActSize, 1, 0, 0, 0, 0, 0), 0);
		send_request(mk(ActSize, 2, 0, 0, 0, 40, 30), 0);
		// hidden slide and refresh
		send_request(mk(ActSlide, 2, 0, -4096, 4095), 0);
		send_request(mk(ActRefresh, 2, 0, 0, 0, 0, 0, 10, 10), 0);
		send_request(mk(ActSlide, 2, 0, 10, 20), 3);
		// insert clamped to top+1, then stay-put
		send_request(mk(ActHeight, 0, 255), 0);
		send_request(mk(ActHeight, 1, -256), 0);
		send_request(mk(ActHeight, 1, 0), 0);
		send_request(mk(ActHeight, 2, 0), 0);
		send_request(mk(ActHeight, 2, 255), 0);
		send_request(mk(ActHeight, 2, 2), 0);
		send_request(mk(ActHeight, 2, 0), 0);
		send_request(mk(ActSlide, 0, 0, -4096, -4096), 0);
		send_request(mk(ActRefresh, 0, 0, -4096, -4096, 0, 0, 4095, 4095), 0);
		send_request(mk(ActRefresh, 2, 0, 30, 20, 5, 5), 0);
		send_request(mk(ActHeight, 0, -1), 0);
		send_request(mk(ActFree, 1), 0);
		send_request(mk(ActFree, 2), 0);
	endtask

	task automatic test_screen_size();
		write_reg(AddrScreenW, 1);
		write_reg(AddrScreenH, 4095);
		run_random(10);
		write_reg(AddrScreenW, 4095);
		write_reg(AddrScreenH, 1);
		run_random(10);
		write_reg(AddrScreenW, 640);
		write_reg(AddrScreenH, 480);
	endtask

	// fill every layer, overflow allocation, then restack and free random layers
	task automatic test_full_stack();
		int i;
		for (i = 0; i < NumLayers; i++) send_request(mk(ActAlloc, 0), pick_gap());
		send_request(mk(ActAlloc, 0), 0);
		send_request(mk(ActAlloc, 0), 5);
		for (i = 0; i < 15; i++)
			send_request(mk(ActHeight, $urandom_range(0, 255), $urandom_range(0, 40)),
				pick_gap());
		for (i = 0; i < 15; i++)
			send_request(mk(ActFree, $urandom_range(0, 255)), pick_gap());
	endtask

	initial begin : stimulus
		int i;
		scr_w = 320;
		scr_h = 200;
		top_h = -1;
		for (i = 0; i < NumLayers; i++) begin
			in_use[i] = 0;
			org_x[i] = 0;
			org_y[i] = 0;
			wid[i] = 0;
			hgt[i] = 0;
			z_of[i] = -1;
			layer_at[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_screen_size();
		test_full_stack();
		run_random(30);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("window_layer_stack_manager verification clean");
		else
			$display("window_layer_stack_manager verification failed");
		$finish;
	end

	task automatic cmp(string name, int e, int a);
		if (e != a) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, e, a);
		end
	endtask

	// result checker: every strobe must match the oldest prediction
	always @(posedge clk) begin
		redraw_t e;
		accepted_now = start && !busy && arst_n;
		if (done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none got kind %0d layer %0d",
					$time, kind, layer_out);
			end else begin
				e = pending_results.pop_front();
				cmp("kind", e.kind, kind);
				cmp("status", e.status, status);
				cmp("layer_out", e.layer, layer_out);
				cmp("rect_x0", e.x0, rect_x0);
				cmp("rect_y0", e.y0, rect_y0);
				cmp("rect_x1", e.x1, rect_x1);
				cmp("rect_y1", e.y1, rect_y1);
				cmp("from_height", e.from_h, from_height);
				cmp("to_height", e.to_h, to_height);
				cmp("last", e.last, last);
			end
		end
		if (done || accepted_now) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (idle_cycles > IdleLimit) begin
			$display("window_layer_stack_manager verification failed");
			$finish;
		end
	end

endmodule
